### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is low
`define BGCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bar graph cell splitter assertion failed");

// clocked assertion that also holds across reset
`define BGCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("bar graph cell splitter reset assertion failed");

`endif

### rtl/bgcs_pkg.sv
// shared types and constants of the bar graph cell splitter
`default_nettype none

package bgcs_pkg;

    // bar direction codes
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    // configuration register indexes
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // register reset values
    localparam logic [5:0] COLS_RESET = 6'd20;
    localparam logic [2:0] ROWS_RESET = 3'd4;

    // most records per bar
    localparam int RECORD_LIMIT = 40;

    // walking position widths, wide enough for any display size
    localparam int COL_W = 7;
    localparam int ROW_W = 4;
    // cell pitch width, holds up to 31 pixels
    localparam int RES_W = 5;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_ok;
        logic last;
        logic slot_free;
    } t_stat;

endpackage

`default_nettype wire

### rtl/bgcs_in_if.sv
// request channel: one bar per beat
`default_nettype none

interface bgcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] direction;
    logic [1:0] start_row;
    logic [5:0] start_col;
    logic [7:0] bar_length;
    logic [7:0] fill_upper;
    logic [7:0] fill_lower;

    modport source (
        output valid, direction, start_row, start_col, bar_length, fill_upper, fill_lower,
        input  ready
    );
    modport sink (
        input  valid, direction, start_row, start_col, bar_length, fill_upper, fill_lower,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bgcs_out_if.sv
// record channel: one character cell per beat
`default_nettype none

interface bgcs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_row;
    logic [5:0] cell_col;
    logic [3:0] cell_fill_a;
    logic [3:0] cell_fill_b;
    logic       last_cell;

    modport source (
        output valid, cell_row, cell_col, cell_fill_a, cell_fill_b, last_cell,
        input  ready
    );
    modport sink (
        input  valid, cell_row, cell_col, cell_fill_a, cell_fill_b, last_cell,
        output ready
    );
endinterface

`default_nettype wire

### rtl/bgcs_ctrl.sv
// sequencer that walks one bar at a time
`default_nettype none

module bgcs_ctrl
    import bgcs_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // a bar off the display or of no length gives no records
                    if (i_stat.start_ok) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/bgcs_datapath.sv
// bar registers, per-cell fill split and record output register
`default_nettype none

module bgcs_datapath
    import bgcs_pkg::*;
#(
    parameter int CELL_WIDTH  = 5,
    parameter int CELL_HEIGHT = 8,
    parameter int MAX_COLS    = 40,
    parameter int MAX_ROWS    = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration writes
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [5:0] i_cfg_data,
    // request fields
    input  wire  [1:0] i_direction,
    input  wire  [1:0] i_start_row,
    input  wire  [5:0] i_start_col,
    input  wire  [7:0] i_bar_length,
    input  wire  [7:0] i_fill_upper,
    input  wire  [7:0] i_fill_lower,
    // record output
    input  wire        i_out_ready,
    output logic       o_out_valid,
    output logic [1:0] o_cell_row,
    output logic [5:0] o_cell_col,
    output logic [3:0] o_cell_fill_a,
    output logic [3:0] o_cell_fill_b,
    output logic       o_last_cell,
    // sequencer link
    input  t_cmd       i_cmd,
    output t_stat      o_stat
);

    localparam logic [COL_W-1:0] MAX_C   = COL_W'(MAX_COLS);
    localparam logic [ROW_W-1:0] MAX_R   = ROW_W'(MAX_ROWS);
    localparam logic [RES_W-1:0] RES_H   = RES_W'(CELL_WIDTH);
    localparam logic [RES_W-1:0] RES_V   = RES_W'(CELL_HEIGHT);
    localparam logic [5:0]       CNT_END = 6'(RECORD_LIMIT - 1);

    typedef struct packed {
        logic [RES_W-1:0] amt;
        logic [7:0]       rest;
    } t_share;

    // share of one fill in the current cell, and what is left after it
    function automatic t_share cell_share(input logic [7:0] rest,
                                          input logic [RES_W-1:0] res,
                                          input logic rev);
        t_share s;
        logic [7:0] res_x;
        res_x = {{(8-RES_W){1'b0}}, res};
        if (rest >= res_x) begin
            s.amt  = rev ? '0 : res;
            s.rest = rest - res_x;
        end else begin
            s.amt  = rev ? (res - rest[RES_W-1:0]) : rest[RES_W-1:0];
            s.rest = '0;
        end
        return s;
    endfunction

    logic [5:0]       r_cols;
    logic [2:0]       r_rows;
    logic             r_horiz;
    logic             r_rev;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [7:0]       r_rem;
    logic [7:0]       r_fa;
    logic [7:0]       r_fb;
    logic [5:0]       r_count;
    logic             r_out_valid;
    logic [1:0]       r_cell_row;
    logic [5:0]       r_cell_col;
    logic [3:0]       r_cell_fill_a;
    logic [3:0]       r_cell_fill_b;
    logic             r_last_cell;

    logic [COL_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_eff;
    logic [7:0]       fa_clamp;
    logic [7:0]       fb_clamp;
    logic             in_horiz;
    logic             in_rev;
    logic [RES_W-1:0] res;
    logic [7:0]       res_x;
    t_share           share_a;
    t_share           share_b;
    logic             edge_next;
    logic             last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // display size limited to the largest supported
    always_comb begin
        cols_eff = ({1'b0, r_cols} > MAX_C) ? MAX_C : {1'b0, r_cols};
        rows_eff = ({1'b0, r_rows} > MAX_R) ? MAX_R : {1'b0, r_rows};
    end

    // request decode and fill clamping
    always_comb begin
        in_horiz = (i_direction == DIR_LEFT) || (i_direction == DIR_RIGHT);
        in_rev   = (i_direction == DIR_LEFT) || (i_direction == DIR_UP);
        if (i_fill_upper == 8'd0) begin
            fa_clamp = 8'd1;
        end else if (i_fill_upper > i_bar_length) begin
            fa_clamp = i_bar_length;
        end else begin
            fa_clamp = i_fill_upper;
        end
        if (i_fill_lower == 8'd0) begin
            fb_clamp = 8'd1;
        end else if (i_fill_lower > i_bar_length) begin
            fb_clamp = i_bar_length;
        end else begin
            fb_clamp = i_fill_lower;
        end
    end

    // current cell
    always_comb begin
        res       = r_horiz ? RES_H : RES_V;
        res_x     = {{(8-RES_W){1'b0}}, res};
        share_a   = cell_share(r_fa, res, r_rev);
        share_b   = cell_share(r_fb, res, r_rev);
        edge_next = r_horiz ? ((r_col + COL_W'(1)) >= cols_eff)
                            : ((r_row + ROW_W'(1)) >= rows_eff);
        last      = !((r_rem > res_x) && (r_count < CNT_END) && !edge_next);
    end

    // status
    always_comb begin
        o_stat.start_ok  = (i_bar_length != 8'd0)
                        && ({{(ROW_W-2){1'b0}}, i_start_row} < rows_eff)
                        && ({{(COL_W-6){1'b0}}, i_start_col} < cols_eff);
        o_stat.last      = last;
        o_stat.slot_free = !r_out_valid || i_out_ready;
    end

    // bar walking registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_horiz <= in_horiz;
            r_rev   <= in_rev;
            r_row   <= {{(ROW_W-2){1'b0}}, i_start_row};
            r_col   <= {{(COL_W-6){1'b0}}, i_start_col};
            r_rem   <= i_bar_length;
            r_fa    <= in_rev ? (i_bar_length - fa_clamp) : fa_clamp;
            r_fb    <= in_rev ? (i_bar_length - fb_clamp) : fb_clamp;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_rem   <= r_rem - res_x;
            r_fa    <= share_a.rest;
            r_fb    <= share_b.rest;
            r_count <= r_count + 6'd1;
            if (r_horiz) begin
                r_col <= r_col + COL_W'(1);
            end else begin
                r_row <= r_row + ROW_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output record payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_cell_row    <= r_row[1:0];
            r_cell_col    <= r_col[5:0];
            r_cell_fill_a <= share_a.amt[3:0];
            r_cell_fill_b <= share_b.amt[3:0];
            r_last_cell   <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_row    = r_cell_row;
    assign o_cell_col    = r_cell_col;
    assign o_cell_fill_a = r_cell_fill_a;
    assign o_cell_fill_b = r_cell_fill_b;
    assign o_last_cell   = r_last_cell;

endmodule

`default_nettype wire

### rtl/bar_graph_cell_splitter.sv
// top level of the bar graph cell splitter
//
// Takes one bar request per beat and splits it into one record per character cell along the
// bar, with the pixels of both fills inside each cell; the final record carries last_cell.
// A request is taken and the sequencer then walks the bar one cell per cycle while the record
// sink does not stall (a stall on the record side holds the walk), so a bar of n cells (n up to
// 40) gives n records, and the next request is taken once the last record has been loaded
// into the output register. A request that starts off the display or has zero length gives no
// records. Configuration writes go to index 0 (display columns) and 1 (display rows) and must
// be made only while no bar is in progress.
`default_nettype none

module bar_graph_cell_splitter
    import bgcs_pkg::*;
#(
    parameter int CELL_WIDTH  = 5,
    parameter int CELL_HEIGHT = 8,
    parameter int MAX_COLS    = 40,
    parameter int MAX_ROWS    = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [5:0] i_cfg_data,
    bgcs_in_if.sink    i_in,
    bgcs_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer
    bgcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath
    bgcs_datapath #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT),
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_direction   (i_in.direction),
        .i_start_row   (i_in.start_row),
        .i_start_col   (i_in.start_col),
        .i_bar_length  (i_in.bar_length),
        .i_fill_upper  (i_in.fill_upper),
        .i_fill_lower  (i_in.fill_lower),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_cell_row    (o_out.cell_row),
        .o_cell_col    (o_out.cell_col),
        .o_cell_fill_a (o_out.cell_fill_a),
        .o_cell_fill_b (o_out.cell_fill_b),
        .o_last_cell   (o_out.last_cell),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

`default_nettype wire

### rtl/bgcs_checker.sv
// port-level checks of the bar graph cell splitter and their bind
`default_nettype none

`include "assert_macros.svh"

module bgcs_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [1:0] i_cell_row,
    input wire [5:0] i_cell_col,
    input wire [3:0] i_cell_fill_a,
    input wire [3:0] i_cell_fill_b,
    input wire       i_last_cell
);

    logic [16:0] rec_bits;

    // whole record payload as one vector
    assign rec_bits = {i_cell_row, i_cell_col, i_cell_fill_a, i_cell_fill_b, i_last_cell};

    // a record beat waits until it is taken
    `BGCS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // a stalled record keeps its payload
    `BGCS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(rec_bits))

    // while a record other than the last is shown the bar is still being walked
    `BGCS_ASSERT(a_busy_mid_bar, i_clk, i_rst_n, i_out_valid && !i_last_cell |-> !i_in_ready)

    // after reset the block is idle with no record pending
    `BGCS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> i_in_ready && !i_out_valid)

endmodule

bind bar_graph_cell_splitter bgcs_checker u_bgcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cell_row    (o_out.cell_row),
    .i_cell_col    (o_out.cell_col),
    .i_cell_fill_a (o_out.cell_fill_a),
    .i_cell_fill_b (o_out.cell_fill_b),
    .i_last_cell   (o_out.last_cell)
);

`default_nettype wire
